[design/msf_pkg.sv]
`default_nettype none
package msf_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES = 256;
	localparam int WEIGHT_BITS = 16;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int NW = $clog2(MAX_EDGES + 1);
	localparam int RW = 3;
	localparam int COST_BITS = 21;
	localparam int DROP_BITS = 8;
	localparam int ENTRY_BITS = 2 * VW + WEIGHT_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_NEXT,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_FIND_A,
		ST_FIND_B,
		ST_JOIN,
		ST_EMIT,
		ST_ROOTS,
		ST_SUMMARY,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic store_edge;
		logic drop_edge;
		logic load_key;
		logic rd_prev;
		logic shift_prev;
		logic put_key;
		logic rd_walk;
		logic load_walk;
		logic find_a;
		logic find_b;
		logic join_roots;
		logic count_root;
		logic clear_all;
		logic start_run;
	} cmd_t;

	typedef struct packed {
		logic store_full;
		logic endpoint_bad;
		logic sort_done;
		logic prev_greater;
		logic j_zero;
		logic walk_done;
		logic walk_skip;
		logic find_done;
		logic same_root;
		logic roots_done;
	} sts_t;
endpackage
`default_nettype wire

[design/msf_if.sv]
`default_nettype none
interface msf_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [4:0] from_vertex;
	logic [4:0] to_vertex;
	logic [15:0] edge_weight;
	modport source(output valid, kind, from_vertex, to_vertex, edge_weight, input ready);
	modport sink(input valid, kind, from_vertex, to_vertex, edge_weight, output ready);
endinterface

interface msf_out_if;
	logic valid;
	logic ready;
	logic is_summary;
	logic [4:0] edge_from;
	logic [4:0] edge_to;
	logic [15:0] chosen_weight;
	logic [20:0] total_cost;
	logic [5:0] component_count;
	logic [7:0] dropped_count;
	logic last;
	modport source(output valid, is_summary, edge_from, edge_to, chosen_weight, total_cost,
		component_count, dropped_count, last, input ready);
	modport sink(input valid, is_summary, edge_from, edge_to, chosen_weight, total_cost,
		component_count, dropped_count, last, output ready);
endinterface
`default_nettype wire

[design/msf_ctrl.sv]
`default_nettype none
module msf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_kind,
	output logic                 in_ready,
	output logic                 out_valid,
	output logic                 out_summary,
	input  wire logic            out_ready,
	input  wire msf_pkg::sts_t   sts,
	output msf_pkg::cmd_t        cmd
);
	msf_pkg::state_t state_q, state_d;
	logic find_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msf_pkg::ST_IDLE;
			find_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == msf_pkg::ST_WALK_CHK) find_b_q <= 1'b0;
			else if (state_q == msf_pkg::ST_FIND_A && sts.find_done) find_b_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msf_pkg::ST_IDLE:
				if (in_valid && in_kind) state_d = msf_pkg::ST_SORT_RD;
			msf_pkg::ST_SORT_RD:
				state_d = sts.sort_done ? msf_pkg::ST_WALK_RD : msf_pkg::ST_SORT_CMP;
			msf_pkg::ST_SORT_CMP:
				state_d = msf_pkg::ST_SORT_NEXT;
			msf_pkg::ST_SORT_NEXT:
				if (!sts.j_zero && sts.prev_greater) state_d = msf_pkg::ST_SORT_CMP;
				else state_d = msf_pkg::ST_SORT_RD;
			msf_pkg::ST_WALK_RD:
				state_d = sts.walk_done ? msf_pkg::ST_ROOTS : msf_pkg::ST_WALK_CHK;
			msf_pkg::ST_WALK_CHK:
				state_d = sts.walk_skip ? msf_pkg::ST_WALK_RD : msf_pkg::ST_FIND_A;
			msf_pkg::ST_FIND_A:
				if (sts.find_done) state_d = msf_pkg::ST_FIND_B;
			msf_pkg::ST_FIND_B:
				if (sts.find_done) state_d = msf_pkg::ST_JOIN;
			msf_pkg::ST_JOIN:
				state_d = sts.same_root ? msf_pkg::ST_WALK_RD : msf_pkg::ST_EMIT;
			msf_pkg::ST_EMIT:
				if (out_ready) state_d = msf_pkg::ST_WALK_RD;
			msf_pkg::ST_ROOTS:
				if (sts.roots_done) state_d = msf_pkg::ST_SUMMARY;
			msf_pkg::ST_SUMMARY:
				if (out_ready) state_d = msf_pkg::ST_CLEAR;
			msf_pkg::ST_CLEAR:
				state_d = msf_pkg::ST_IDLE;
			default: state_d = msf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_summary = 1'b0;
		unique case (state_q)
			msf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !in_kind) begin
					cmd.store_edge = !sts.store_full && !sts.endpoint_bad;
					cmd.drop_edge = sts.store_full || sts.endpoint_bad;
				end
				cmd.start_run = in_valid && in_kind;
			end
			msf_pkg::ST_SORT_RD: cmd.load_key = !sts.sort_done;
			msf_pkg::ST_SORT_CMP: cmd.rd_prev = 1'b1;
			msf_pkg::ST_SORT_NEXT: begin
				if (!sts.j_zero && sts.prev_greater) cmd.shift_prev = 1'b1;
				else cmd.put_key = 1'b1;
			end
			msf_pkg::ST_WALK_RD: cmd.rd_walk = !sts.walk_done;
			msf_pkg::ST_WALK_CHK: cmd.load_walk = !sts.walk_skip;
			msf_pkg::ST_FIND_A: cmd.find_a = 1'b1;
			msf_pkg::ST_FIND_B: cmd.find_b = 1'b1;
			msf_pkg::ST_JOIN: cmd.join_roots = !sts.same_root;
			msf_pkg::ST_EMIT: out_valid = 1'b1;
			msf_pkg::ST_ROOTS: cmd.count_root = 1'b1;
			msf_pkg::ST_SUMMARY: begin
				out_valid = 1'b1;
				out_summary = 1'b1;
			end
			msf_pkg::ST_CLEAR: cmd.clear_all = 1'b1;
			default: ;
		endcase
		cmd.find_b = cmd.find_b & find_b_q | (state_q == msf_pkg::ST_FIND_B);
	end
endmodule
`default_nettype wire

[design/msf_datapath.sv]
`default_nettype none
module msf_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [5:0]                        cfg_wdata,
	input  wire logic [4:0]                        in_from,
	input  wire logic [4:0]                        in_to,
	input  wire logic [15:0]                       in_weight,
	input  wire msf_pkg::cmd_t                     cmd,
	output msf_pkg::sts_t                          sts,
	output logic [msf_pkg::VW-1:0]                 e_from,
	output logic [msf_pkg::VW-1:0]                 e_to,
	output logic [msf_pkg::WEIGHT_BITS-1:0]        e_weight,
	output logic [msf_pkg::COST_BITS-1:0]          cost,
	output logic [msf_pkg::CW-1:0]                 roots,
	output logic [msf_pkg::DROP_BITS-1:0]          drops
);
	localparam int VW = msf_pkg::VW;
	localparam int WB = msf_pkg::WEIGHT_BITS;
	localparam int EB = msf_pkg::ENTRY_BITS;
	localparam int CW_A = 7;

	logic [EB-1:0] mem [msf_pkg::MAX_EDGES];
	logic [EB-1:0] rd_q, key_q;
	logic [msf_pkg::NW-1:0] n_q, i_q, j_q;
	logic [5:0] vc_q;
	logic [msf_pkg::DROP_BITS-1:0] drops_q;
	logic [msf_pkg::COST_BITS-1:0] cost_q;
	logic [msf_pkg::CW-1:0] roots_q;
	logic [VW-1:0] parent_q [msf_pkg::MAX_VERTICES];
	logic [msf_pkg::RW-1:0] rank_q [msf_pkg::MAX_VERTICES];
	logic [VW-1:0] cur_q, start_q, ra_q, rb_q;
	logic compress_q;
	logic find_sel_q;
	logic walk_phase_q;
	logic [VW:0] rv_q;

	logic [CW_A-1:0] act;
	logic [EB-1:0] wr_data;
	logic [msf_pkg::EW-1:0] wr_addr, rd_addr;
	logic wr_en, rd_en;
	logic [VW-1:0] rd_from, rd_to;
	logic [WB-1:0] rd_w, key_w;
	logic [VW-1:0] pc;
	logic [VW-1:0] tgt;
	logic sort_end;

	always_comb begin
		if (vc_q == 6'd0) act = CW_A'(1);
		else if ({1'b0, vc_q} > CW_A'(msf_pkg::MAX_VERTICES)) act = CW_A'(msf_pkg::MAX_VERTICES);
		else act = CW_A'(vc_q);
	end

	assign rd_from = rd_q[EB-1 -: VW];
	assign rd_to = rd_q[EB-1-VW -: VW];
	assign rd_w = rd_q[WB-1:0];
	assign key_w = key_q[WB-1:0];
	assign pc = parent_q[cur_q];
	assign tgt = find_sel_q ? rb_q : ra_q;
	assign sort_end = !walk_phase_q && sts.sort_done && !cmd.load_key && !cmd.start_run;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = n_q[msf_pkg::EW-1:0];
		wr_data = {in_from[VW-1:0], in_to[VW-1:0], in_weight[WB-1:0]};
		rd_en = 1'b0;
		rd_addr = i_q[msf_pkg::EW-1:0];
		if (cmd.store_edge) wr_en = 1'b1;
		if (cmd.shift_prev) begin
			wr_en = 1'b1;
			wr_addr = j_q[msf_pkg::EW-1:0];
			wr_data = rd_q;
		end
		if (cmd.put_key) begin
			wr_en = 1'b1;
			wr_addr = j_q[msf_pkg::EW-1:0];
			wr_data = key_q;
		end
		if (cmd.load_key || cmd.rd_walk) rd_en = 1'b1;
		if (cmd.rd_prev) begin
			rd_en = 1'b1;
			rd_addr = msf_pkg::EW'(j_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 6'd32;
			n_q <= '0;
			drops_q <= '0;
			i_q <= '0;
			j_q <= '0;
			cost_q <= '0;
			roots_q <= '0;
			compress_q <= 1'b0;
			find_sel_q <= 1'b0;
			cur_q <= '0;
			start_q <= '0;
			ra_q <= '0;
			rb_q <= '0;
			rv_q <= '0;
			for (int k = 0; k < msf_pkg::MAX_VERTICES; k++) begin
				parent_q[k] <= VW'(k);
				rank_q[k] <= '0;
			end
		end else begin
			if (cfg_we) vc_q <= cfg_wdata;
			if (cmd.store_edge) n_q <= n_q + 1'b1;
			if (cmd.drop_edge && drops_q != '1) drops_q <= drops_q + 1'b1;
			if (cmd.start_run) begin
				i_q <= msf_pkg::NW'(1);
				cost_q <= '0;
				roots_q <= '0;
				rv_q <= '0;
			end
			if (cmd.load_key) j_q <= i_q;
			if (cmd.shift_prev) j_q <= j_q - 1'b1;
			if (cmd.put_key) i_q <= i_q + 1'b1;
			if (sort_end) i_q <= '0;
			if (cmd.rd_walk) i_q <= i_q + 1'b1;
			if (cmd.load_walk) begin
				cur_q <= rd_from;
				start_q <= rd_from;
				find_sel_q <= 1'b0;
			end
			if (cmd.find_a || cmd.find_b) begin
				if (!compress_q) begin
					if (pc == cur_q) begin
						compress_q <= 1'b1;
						if (cmd.find_b) rb_q <= cur_q;
						else ra_q <= cur_q;
						cur_q <= start_q;
					end else cur_q <= pc;
				end else begin
					if (pc == tgt) begin
						compress_q <= 1'b0;
						find_sel_q <= 1'b1;
						cur_q <= rd_to;
						start_q <= rd_to;
					end else begin
						parent_q[cur_q] <= tgt;
						cur_q <= pc;
					end
				end
			end
			if (cmd.join_roots) begin
				cost_q <= cost_q + msf_pkg::COST_BITS'(rd_w);
				if (rank_q[ra_q] > rank_q[rb_q]) parent_q[rb_q] <= ra_q;
				else if (rank_q[ra_q] < rank_q[rb_q]) parent_q[ra_q] <= rb_q;
				else begin
					parent_q[rb_q] <= ra_q;
					if (rank_q[ra_q] != '1) rank_q[ra_q] <= rank_q[ra_q] + 1'b1;
				end
			end
			if (cmd.count_root && !sts.roots_done) begin
				if (parent_q[rv_q[VW-1:0]] == rv_q[VW-1:0]) roots_q <= roots_q + 1'b1;
				rv_q <= rv_q + 1'b1;
			end
			if (cmd.clear_all) begin
				n_q <= '0;
				drops_q <= '0;
				for (int k = 0; k < msf_pkg::MAX_VERTICES; k++) begin
					parent_q[k] <= VW'(k);
					rank_q[k] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) walk_phase_q <= 1'b0;
		else if (cmd.start_run) walk_phase_q <= 1'b0;
		else if (sort_end) walk_phase_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) key_q <= mem[i_q[msf_pkg::EW-1:0]];
	end

	always_comb begin
		sts.store_full = n_q >= msf_pkg::NW'(msf_pkg::MAX_EDGES);
		sts.endpoint_bad = (CW_A'(in_from) >= act) || (CW_A'(in_to) >= act);
		sts.sort_done = walk_phase_q || (i_q >= n_q);
		sts.prev_greater = rd_w > key_w;
		sts.j_zero = j_q == '0;
		sts.walk_done = walk_phase_q ? (i_q >= n_q) : 1'b0;
		sts.walk_skip = (CW_A'(rd_from) >= act) || (CW_A'(rd_to) >= act);
		sts.find_done = compress_q && (pc == tgt);
		sts.same_root = ra_q == rb_q;
		sts.roots_done = CW_A'(rv_q) >= act;
	end

	assign e_from = rd_from;
	assign e_to = rd_to;
	assign e_weight = rd_w;
	assign cost = cost_q;
	assign roots = roots_q;
	assign drops = drops_q;
endmodule
`default_nettype wire

[design/minimum_spanning_forest_unit.sv]
`default_nettype none
// edge transaction: accepted while idle, back to back
// run over n stored edges: insertion sort by weight, shifting larger edges up;
// then a walk over the sorted edges, and for a kept edge a find per endpoint
// with path compression, a join and an emit held until the sink is ready
// roots counted over the active vertices, then summary held until ready, then clear
// reset: asynchronous, empties the store, clears drops and forest, vertex_count to 32
module minimum_spanning_forest_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic [5:0] cfg_wdata,
	msf_in_if.sink      in_ch,
	msf_out_if.source   out_ch
);
	msf_pkg::cmd_t cmd;
	msf_pkg::sts_t sts;
	logic summary;
	logic [msf_pkg::VW-1:0] e_from, e_to;
	logic [msf_pkg::WEIGHT_BITS-1:0] e_weight;
	logic [msf_pkg::COST_BITS-1:0] cost;
	logic [msf_pkg::CW-1:0] roots;
	logic [msf_pkg::DROP_BITS-1:0] drops;

	msf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_summary(summary), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	msf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_from(in_ch.from_vertex), .in_to(in_ch.to_vertex), .in_weight(in_ch.edge_weight),
		.cmd(cmd), .sts(sts), .e_from(e_from), .e_to(e_to), .e_weight(e_weight),
		.cost(cost), .roots(roots), .drops(drops)
	);

	assign out_ch.is_summary = summary;
	assign out_ch.last = summary;
	assign out_ch.edge_from = summary ? 5'd0 : 5'(e_from);
	assign out_ch.edge_to = summary ? 5'd0 : 5'(e_to);
	assign out_ch.chosen_weight = summary ? 16'd0 : 16'(e_weight);
	assign out_ch.total_cost = summary ? 21'(cost) : 21'd0;
	assign out_ch.component_count = summary ? 6'(roots) : 6'd0;
	assign out_ch.dropped_count = summary ? 8'(drops) : 8'd0;
endmodule
`default_nettype wire

[sim/minimum_spanning_forest_unit_test.sv]
`default_nettype none
module minimum_spanning_forest_unit_test;
	localparam int HANG_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic is_summary;
		logic [4:0] edge_from;
		logic [4:0] edge_to;
		logic [15:0] chosen_weight;
		logic [20:0] total_cost;
		logic [5:0] component_count;
		logic [7:0] dropped_count;
		logic last;
	} forest_item_t;

	typedef struct packed {
		logic [4:0] from_v;
		logic [4:0] to_v;
		logic [15:0] weight;
	} edge_rec_t;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [5:0] cfg_wdata;

	msf_in_if in_ch();
	msf_out_if out_ch();

	minimum_spanning_forest_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// forest model state
	edge_rec_t edge_list[$];
	logic [7:0] drop_total;
	logic [5:0] vertex_reg;
	logic [4:0] parent[msf_pkg::MAX_VERTICES];
	logic [2:0] rank[msf_pkg::MAX_VERTICES];
	forest_item_t pending_results[$];

	int errors = 0;
	int idle_free = 0;
	int hold_requests = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_vertices();
		if (vertex_reg == 0)
			return 1;
		if (vertex_reg > msf_pkg::MAX_VERTICES)
			return msf_pkg::MAX_VERTICES;
		return vertex_reg;
	endfunction

	function automatic logic [4:0] root_of(logic [4:0] v);
		logic [4:0] r;
		logic [4:0] nxt;
		r = v;
		while (parent[r] != r)
			r = parent[r];
		while (parent[v] != r) begin
			nxt = parent[v];
			parent[v] = r;
			v = nxt;
		end
		return r;
	endfunction

	function automatic void reset_forest();
		for (int i = 0; i < msf_pkg::MAX_VERTICES; i++) begin
			parent[i] = i[4:0];
			rank[i] = '0;
		end
	endfunction

	function automatic void predict_forest(logic kind, logic [4:0] f, logic [4:0] t,
		logic [15:0] w);
		int n;
		int j;
		edge_rec_t sorted[$];
		edge_rec_t key;
		edge_rec_t e;
		logic [4:0] ra;
		logic [4:0] rb;
		logic [20:0] cost;
		int roots;
		forest_item_t res;
		n = active_vertices();
		if (kind == KIND_ADD) begin
			if (edge_list.size() >= msf_pkg::MAX_EDGES || f >= n || t >= n) begin
				if (drop_total != 8'd255)
					drop_total++;
			end else begin
				edge_list = {edge_list, edge_rec_t'({f, t, w})};
			end
			return;
		end
		sorted = edge_list;
		for (int i = 1; i < sorted.size(); i++) begin
			key = sorted[i];
			j = i;
			while (j > 0 && sorted[j - 1].weight > key.weight) begin
				sorted[j] = sorted[j - 1];
				j--;
			end
			sorted[j] = key;
		end
		cost = '0;
		foreach (sorted[i]) begin
			e = sorted[i];
			if (e.from_v >= n || e.to_v >= n)
				continue;
			ra = root_of(e.from_v);
			rb = root_of(e.to_v);
			if (ra == rb)
				continue;
			if (rank[ra] > rank[rb])
				parent[rb] = ra;
			else if (rank[ra] < rank[rb])
				parent[ra] = rb;
			else begin
				parent[rb] = ra;
				if (rank[ra] != 3'd7)
					rank[ra]++;
			end
			cost = cost + 21'(e.weight);
			res = '0;
			res.edge_from = e.from_v;
			res.edge_to = e.to_v;
			res.chosen_weight = e.weight;
			pending_results = {pending_results, res};
		end
		roots = 0;
		for (int i = 0; i < n; i++)
			if (root_of(i[4:0]) == i[4:0])
				roots++;
		res = '0;
		res.is_summary = 1'b1;
		res.total_cost = cost;
		res.component_count = roots[5:0];
		res.dropped_count = drop_total;
		res.last = 1'b1;
		pending_results = {pending_results, res};
		edge_list.delete();
		drop_total = '0;
		reset_forest();
	endfunction

	function automatic bit take_idle();
		return idle_free == 0 && $urandom_range(0, 99) < 27;
	endfunction

	// receiver, with long holds counted here
	initial begin
		int seen;
		seen = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen) begin
				seen = hold_requests;
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready = !take_idle();
		end
	end

	// result checker
	always @(posedge clk) begin
		forest_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transaction from block");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.is_summary !== want.is_summary) begin
					$error("is_summary: expected %0d got %0d", want.is_summary, out_ch.is_summary);
					errors++;
				end
				if (out_ch.edge_from !== want.edge_from) begin
					$error("edge_from: expected %0d got %0d", want.edge_from, out_ch.edge_from);
					errors++;
				end
				if (out_ch.edge_to !== want.edge_to) begin
					$error("edge_to: expected %0d got %0d", want.edge_to, out_ch.edge_to);
					errors++;
				end
				if (out_ch.chosen_weight !== want.chosen_weight) begin
					$error("chosen_weight: expected %0d got %0d", want.chosen_weight,
						out_ch.chosen_weight);
					errors++;
				end
				if (out_ch.total_cost !== want.total_cost) begin
					$error("total_cost: expected %0d got %0d", want.total_cost, out_ch.total_cost);
					errors++;
				end
				if (out_ch.component_count !== want.component_count) begin
					$error("component_count: expected %0d got %0d", want.component_count,
						out_ch.component_count);
					errors++;
				end
				if (out_ch.dropped_count !== want.dropped_count) begin
					$error("dropped_count: expected %0d got %0d", want.dropped_count,
						out_ch.dropped_count);
					errors++;
				end
				if (out_ch.last !== want.last) begin
					$error("last: expected %0d got %0d", want.last, out_ch.last);
					errors++;
				end
			end
		end
	end

	// watchdog on transactions
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_item(logic kind, logic [4:0] f, logic [4:0] t, logic [15:0] w);
		while (take_idle()) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.kind = kind;
		in_ch.from_vertex = f;
		in_ch.to_vertex = t;
		in_ch.edge_weight = w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_forest(kind, f, t, w);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic add_edge(logic [4:0] f, logic [4:0] t, logic [15:0] w);
		send_item(KIND_ADD, f, t, w);
	endtask

	task automatic run_forest();
		send_item(KIND_RUN, 5'($urandom), 5'($urandom), 16'($urandom));
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_vertices(logic [5:0] v);
		drain_results();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		vertex_reg = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_empty_run();
		run_forest();
		set_vertices(6'd1);
		run_forest();
	endtask

	task automatic test_basic_forest();
		set_vertices(6'd32);
		add_edge(5'd0, 5'd31, 16'hFFFF);
		add_edge(5'd31, 5'd0, 16'd0);
		add_edge(5'd3, 5'd3, 16'd1);
		add_edge(5'd1, 5'd2, 16'd7);
		add_edge(5'd2, 5'd3, 16'd7);
		add_edge(5'd1, 5'd3, 16'd7);
		add_edge(5'd21, 5'd10, 16'hAAAA);
		add_edge(5'd10, 5'd21, 16'h5555);
		run_forest();
	endtask

	task automatic test_vertex_limits();
		set_vertices(6'd5);
		add_edge(5'd4, 5'd0, 16'd3);
		add_edge(5'd5, 5'd0, 16'd3);
		add_edge(5'd0, 5'd31, 16'd3);
		add_edge(5'd3, 5'd2, 16'd9);
		run_forest();
		set_vertices(6'd0);
		add_edge(5'd0, 5'd0, 16'd4);
		add_edge(5'd0, 5'd1, 16'd4);
		run_forest();
		set_vertices(6'd63);
		add_edge(5'd31, 5'd30, 16'd2);
		run_forest();
	endtask

	task automatic test_lowered_count();
		set_vertices(6'd32);
		add_edge(5'd20, 5'd1, 16'd1);
		add_edge(5'd1, 5'd2, 16'd5);
		add_edge(5'd2, 5'd3, 16'd6);
		set_vertices(6'd4);
		run_forest();
	endtask

	task automatic test_output_stall();
		set_vertices(6'd8);
		hold_requests++;
		for (int r = 0; r < 4; r++) begin
			for (int i = 0; i < 6; i++)
				add_edge(5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)), 16'($urandom));
			run_forest();
		end
	endtask

	task automatic test_full_store();
		set_vertices(6'd32);
		idle_free = 1;
		for (int i = 0; i < msf_pkg::MAX_EDGES + 4; i++)
			add_edge(5'($urandom), 5'($urandom), 16'($urandom_range(0, 15)));
		idle_free = 0;
		run_forest();
	endtask

	task automatic test_drop_saturation();
		set_vertices(6'd1);
		idle_free = 1;
		for (int i = 0; i < 260; i++)
			add_edge(5'($urandom_range(1, 31)), 5'($urandom), 16'($urandom));
		idle_free = 0;
		run_forest();
	endtask

	task automatic test_random_forests();
		int sent;
		int n;
		sent = 0;
		while (sent < 150) begin
			if ($urandom_range(0, 3) == 0)
				set_vertices($urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(1, 32)));
			n = active_vertices();
			if (sent > 60 && sent < 80)
				idle_free = 1;
			else
				idle_free = 0;
			for (int i = $urandom_range(0, 20); i > 0; i--) begin
				if ($urandom_range(0, 9) == 0)
					add_edge(5'($urandom), 5'($urandom), 16'($urandom));
				else
					add_edge(5'($urandom_range(0, n - 1)), 5'($urandom_range(0, n - 1)),
						$urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8)));
				sent++;
			end
			run_forest();
			sent++;
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end
		idle_free = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_ADD;
		in_ch.from_vertex = '0;
		in_ch.to_vertex = '0;
		in_ch.edge_weight = '0;
		vertex_reg = 6'd32;
		drop_total = '0;
		reset_forest();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_run();
		test_basic_forest();
		test_vertex_limits();
		test_lowered_count();
		test_output_stall();
		test_full_store();
		test_drop_saturation();
		test_random_forests();
		drain_results();
		if (errors == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
design/msf_pkg.sv
design/msf_if.sv
design/msf_ctrl.sv
design/msf_datapath.sv
design/minimum_spanning_forest_unit.sv
sim/minimum_spanning_forest_unit_test.sv
